// File: design/ufct_pkg.sv
// Shared types and constants for the UDP fragment completion tracker.
`timescale 1ns / 1ps

package ufct_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int MAX_FRAGS   = 64;

  localparam int ADDR_W  = 48;
  localparam int SEQ_W   = 32;
  localparam int IDX_W   = 6;
  localparam int TOTAL_W = 7;
  localparam int COUNT_W = 7;
  localparam int SLOT_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int FRAG_W  = $clog2(MAX_FRAGS);

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [MAX_FRAGS-1:0] bitmap_t;

  typedef enum logic [0:0] {
    OP_FRAG   = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_TRACKED     = 4'd0,
    ST_COMPLETE    = 4'd1,
    ST_DUPLICATE   = 4'd2,
    ST_STALE       = 4'd3,
    ST_FULL        = 4'd4,
    ST_BAD_INDEX   = 4'd5,
    ST_REMOVED     = 4'd6,
    ST_REMOVE_MISS = 4'd7,
    ST_RESTARTED   = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    WR_START = 2'd0,
    WR_ADD   = 2'd1,
    WR_CLEAR = 2'd2
  } wr_kind_t;

  typedef struct packed {
    op_t    op;
    addr_t  addr;
    seq_t   seq;
    idx_t   idx;
    total_t total;
  } req_t;

  typedef struct packed {
    logic   hit;
    slot_t  hit_slot;
    logic   free_found;
    slot_t  free_slot;
    seq_t   e_seq;
    total_t e_total;
    bitmap_t e_bitmap;
    count_t e_count;
  } lookup_t;

  typedef struct packed {
    logic              en;
    wr_kind_t          kind;
    slot_t             slot;
    addr_t             addr;
    seq_t              seq;
    total_t            total;
    logic [FRAG_W-1:0] bit_idx;
  } wr_t;

  typedef struct packed {
    logic    is_last;
    status_t status;
    count_t  count;
  } result_t;

endpackage

// File: design/udp_fragment_completion_tracker.sv
// Top level of the UDP fragment completion tracker.
//
// Slave side takes one request per handshake: a fragment header or a
// remove request (opcode in s_tuser). Each request yields exactly one
// result on the master side: received count in m_tdata, status code in
// m_tuser, and m_tlast high when the fragment completes its message.
//
// A request is captured in an input register; once the result register is
// free or being taken, it is matched in parallel against all sixteen table
// entries, the table is updated and the result registered. One request is
// taken every cycle while the receiver does not stall, through the single
// match/update pass over the entry table.
//
// Reset clears all entry valid bits and the valid flags of both pipeline
// registers. When the receiver stalls, the result register holds and the input
// register keeps one more request; s_tready then drops until the result is
// taken.
`timescale 1ns / 1ps

module udp_fragment_completion_tracker import ufct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // src_addr[47:0], msg_seq[79:48], frag_index[85:80],
                                 // frag_total[92:86], zero pad
  input  logic [0:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // received_count[6:0], zero pad
  output logic        m_tlast,   // is_last
  output logic [3:0]  m_tuser    // status
);

  logic    in_valid;
  req_t    req;
  result_t res_r;
  result_t res;
  lookup_t lk;
  wr_t     wr;
  wr_t     wr_q;
  logic    advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.op    <= op_t'(s_tuser[0]);
      req.addr  <= s_tdata[47:0];
      req.seq   <= s_tdata[79:48];
      req.idx   <= s_tdata[85:80];
      req.total <= s_tdata[92:86];
    end
    if (advance) begin
      res_r <= res;
    end
  end

  ufct_decide u_decide (
    .req (req),
    .lk  (lk),
    .res (res),
    .wr  (wr)
  );

  always_comb begin
    wr_q    = wr;
    wr_q.en = wr.en && advance;
  end

  ufct_table u_table (
    .clk  (clk),
    .rst  (rst),
    .addr (req.addr),
    .wr   (wr_q),
    .lk   (lk)
  );

  assign m_tdata = {1'b0, res_r.count};
  assign m_tlast = res_r.is_last;
  assign m_tuser = res_r.status;

  a_last_is_complete: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> res_r.status == ST_COMPLETE)
    else $error("completion flag without complete status");

  a_remove_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_r.status == ST_REMOVED || res_r.status == ST_REMOVE_MISS)
      |-> res_r.count == '0 && !m_tlast)
    else $error("remove result carries count or completion");

  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(advance))
    else $error("result appeared without a processed request");

  a_clear_needs_hit: assert property (@(posedge clk) disable iff (rst)
    wr_q.en && wr_q.kind == WR_CLEAR |-> lk.hit)
    else $error("entry cleared without address match");

  a_start_free_slot: assert property (@(posedge clk) disable iff (rst)
    wr_q.en && wr_q.kind == WR_START && !lk.hit |-> lk.free_found)
    else $error("new entry started with table full");

endmodule

// File: design/ufct_table.sv
// Per-source entry table with parallel address match and free-slot search.
`timescale 1ns / 1ps

module ufct_table import ufct_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  addr_t   addr,
  input  wr_t     wr,
  output lookup_t lk
);

  logic    entry_valid  [NUM_SOURCES];
  addr_t   entry_addr   [NUM_SOURCES];
  seq_t    entry_seq    [NUM_SOURCES];
  total_t  entry_total  [NUM_SOURCES];
  bitmap_t entry_bitmap [NUM_SOURCES];
  count_t  entry_count  [NUM_SOURCES];

  logic [NUM_SOURCES-1:0] match;
  slot_t                  hit_slot;
  slot_t                  free_slot;
  logic                   free_found;

  always_comb begin
    hit_slot   = '0;
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_addr[i] == addr);
      if (match[i]) begin
        hit_slot = SLOT_W'(i);
      end
      if (!entry_valid[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    lk.hit        = |match;
    lk.hit_slot   = hit_slot;
    lk.free_found = free_found;
    lk.free_slot  = free_slot;
    lk.e_seq      = entry_seq[hit_slot];
    lk.e_total    = entry_total[hit_slot];
    lk.e_bitmap   = entry_bitmap[hit_slot];
    lk.e_count    = entry_count[hit_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (wr.en) begin
      case (wr.kind)
        WR_START: entry_valid[wr.slot] <= 1'b1;
        WR_CLEAR: entry_valid[wr.slot] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      case (wr.kind)
        WR_START: begin
          entry_addr[wr.slot]   <= wr.addr;
          entry_seq[wr.slot]    <= wr.seq;
          entry_total[wr.slot]  <= wr.total;
          entry_bitmap[wr.slot] <= bitmap_t'(1) << wr.bit_idx;
          entry_count[wr.slot]  <= COUNT_W'(1);
        end
        WR_ADD: begin
          entry_bitmap[wr.slot] <= entry_bitmap[wr.slot] | (bitmap_t'(1) << wr.bit_idx);
          entry_count[wr.slot]  <= entry_count[wr.slot] + COUNT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/ufct_decide.sv
// Per-request decision: result fields and the table update they imply.
`timescale 1ns / 1ps

module ufct_decide import ufct_pkg::*; (
  input  req_t    req,
  input  lookup_t lk,
  output result_t res,
  output wr_t     wr
);

  logic   bad;
  logic   bit_set;
  count_t count_hit;

  always_comb begin
    bad = (req.total == '0) || (req.total > TOTAL_W'(MAX_FRAGS)) ||
          ({1'b0, req.idx} >= req.total);
    bit_set   = lk.e_bitmap[req.idx[FRAG_W-1:0]];
    count_hit = lk.hit ? lk.e_count : '0;

    res.is_last = 1'b0;
    res.status  = ST_TRACKED;
    res.count   = count_hit;

    wr.en      = 1'b0;
    wr.kind    = WR_START;
    wr.slot    = lk.hit_slot;
    wr.addr    = req.addr;
    wr.seq     = req.seq;
    wr.total   = req.total;
    wr.bit_idx = req.idx[FRAG_W-1:0];

    if (req.op == OP_REMOVE) begin
      res.count = '0;
      if (lk.hit) begin
        res.status = ST_REMOVED;
        wr.en      = 1'b1;
        wr.kind    = WR_CLEAR;
      end else begin
        res.status = ST_REMOVE_MISS;
      end
    end else if (bad) begin
      res.status = ST_BAD_INDEX;
    end else if (req.total == TOTAL_W'(1)) begin
      res.is_last = 1'b1;
      res.status  = ST_COMPLETE;
    end else if (!lk.hit) begin
      if (!lk.free_found) begin
        res.status = ST_FULL;
      end else begin
        res.count = COUNT_W'(1);
        wr.en     = 1'b1;
        wr.slot   = lk.free_slot;
      end
    end else if (lk.e_count == '0) begin
      res.count = COUNT_W'(1);
      wr.en     = 1'b1;
    end else if (req.seq < lk.e_seq) begin
      res.status = ST_STALE;
    end else if (req.seq > lk.e_seq) begin
      res.status = ST_RESTARTED;
      res.count  = COUNT_W'(1);
      wr.en      = 1'b1;
    end else if (req.total != lk.e_total) begin
      res.status = ST_BAD_INDEX;
    end else if (bit_set) begin
      res.status = ST_DUPLICATE;
    end else if ((lk.e_count + COUNT_W'(1)) == lk.e_total) begin
      // final missing fragment: report, leave entry untouched
      res.is_last = 1'b1;
      res.status  = ST_COMPLETE;
    end else begin
      res.count = lk.e_count + COUNT_W'(1);
      wr.en     = 1'b1;
      wr.kind   = WR_ADD;
    end
  end

endmodule
